>>> rtl/core/aewd_pkg.sv
// Package for the ADC event word deframer.
// Holds phase codes, field positions, the result type and its packing.
// No dependencies.
package aewd_pkg;

    localparam int unsigned NUM_KEPT   = 8;
    localparam int unsigned VAL_W      = 14;
    localparam int unsigned TRIG_W     = 30;
    localparam int unsigned MOD_W      = 8;
    localparam int unsigned TALLY_W    = 16;
    localparam int unsigned COUNT_W    = 12;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned RES_BITS   = NUM_KEPT * VAL_W + TRIG_W + MOD_W + TALLY_W;
    localparam int unsigned OUT_DATA_W = ((RES_BITS + 7) / 8) * 8;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_FOOT = 2'd2;

    localparam logic [1:0]         HDR_SIG   = 2'b01;
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};

    typedef logic [VAL_W-1:0] t_chan_val;

    typedef struct packed {
        logic [TALLY_W-1:0] bad_words;
        logic [MOD_W-1:0]   source_module;
        logic [TRIG_W-1:0]  trigger_count;
        t_chan_val [NUM_KEPT-1:0] chan_value;
    } t_result;

    // chan0 lands in the lowest bits, padding zeros on top
    function automatic logic [OUT_DATA_W-1:0] pack_result(input t_result res);
        logic [OUT_DATA_W-1:0] packed_word;
        packed_word = '0;
        packed_word[RES_BITS-1:0] = res;
        return packed_word;
    endfunction

endpackage

>>> rtl/core/adc_event_word_deframer_top.sv
// ADC event word deframer, top level.
// Splits a stream of 32-bit readout words into events and emits one result per event.
// Readout words enter on s_axis, one word per transfer (tdata bits 31:0).
// A header (bits 31:30 equal to one) opens an event and gives the module id
// and word count; count minus one data words follow, then a footer whose
// 30-bit trigger counter closes the event. At the footer a result leaves on
// m_axis: eight channel values, trigger counter, module id and bad word tally.
// Non-header words outside an event bump a saturating 16-bit tally.
// A footer passes the input register and the decode, then loads the result
// register, which raises m_axis_tvalid. Throughput: one word per cycle while
// the result register can advance, set by the decode between the two registers.
// A stalled receiver freezes the pipe once the result register is full and held;
// s_axis_tready drops when the input register is full, until m_axis_tready returns.
// Reset (synchronous, active low) empties both registers, returns to waiting
// for a header and clears channel values, module id and tally to zero.
module adc_event_word_deframer_top
    import aewd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // data_word[31:0]
    input  logic [WORD_W-1:0]     s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // chan0_value..chan7_value (14 each), trigger_count[30], source_module[8],
    // bad_words[16], zero padding
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    logic              w_advance;
    logic              w_in_valid;
    logic [WORD_W-1:0] w_in_word;
    logic              w_step;
    logic              w_emit;
    t_result           w_result;

    assign w_step = w_in_valid && w_advance;

    aewd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_word    (s_axis_tdata),
        .i_advance (w_advance),
        .o_valid   (w_in_valid),
        .o_word    (w_in_word)
    );

    aewd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_word   (w_in_word),
        .o_emit   (w_emit),
        .o_result (w_result)
    );

    aewd_out_reg u_out_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (w_emit),
        .i_result  (w_result),
        .o_advance (w_advance),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule

>>> rtl/core/aewd_in_reg.sv
// Input register stage of the ADC event word deframer.
// Captures one readout word per transfer; depends on aewd_pkg.
module aewd_in_reg
    import aewd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [WORD_W-1:0] i_word,
    input  logic              i_advance,
    output logic              o_valid,
    output logic [WORD_W-1:0] o_word
);

    logic              r_valid;
    logic [WORD_W-1:0] r_word;
    logic              w_accept;

    assign o_ready  = !r_valid || i_advance;
    assign w_accept = i_valid && o_ready;
    assign o_valid  = r_valid;
    assign o_word   = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_word <= i_word;
        end
    end

endmodule

>>> rtl/core/aewd_decode.sv
// Event framing logic: phase, word countdown, channel store and bad word tally.
// Decodes one word per step and flags the footer result; depends on aewd_pkg.
module aewd_decode
    import aewd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [WORD_W-1:0] i_word,
    output logic              o_emit,
    output t_result           o_result
);

    logic [1:0]               r_phase,      n_phase;
    logic [COUNT_W-1:0]       r_words_left, n_words_left;
    t_chan_val [NUM_KEPT-1:0] r_store,      n_store;
    logic [MOD_W-1:0]         r_module,     n_module;
    logic [TALLY_W-1:0]       r_tally,      n_tally;

    logic [4:0]         w_chan;
    logic [COUNT_W-1:0] w_count;
    logic [COUNT_W-1:0] w_left_dec;

    assign w_chan     = i_word[20:16];
    assign w_count    = i_word[COUNT_W-1:0];
    assign w_left_dec = r_words_left - COUNT_W'(1);

    always_comb begin
        n_phase      = r_phase;
        n_words_left = r_words_left;
        n_store      = r_store;
        n_module     = r_module;
        n_tally      = r_tally;
        o_emit       = 1'b0;
        case (r_phase)
            PH_DATA: begin
                if (w_chan < 5'(NUM_KEPT)) begin
                    n_store[w_chan[2:0]] = i_word[VAL_W-1:0];
                end
                n_words_left = w_left_dec;
                if (w_left_dec == '0) begin
                    n_phase = PH_FOOT;
                end
            end
            PH_FOOT: begin
                o_emit  = i_step;
                n_phase = PH_IDLE;
            end
            default: begin
                // idle, and the unused code behaves the same
                if (i_word[31:30] == HDR_SIG) begin
                    n_module = i_word[23:16];
                    if (w_count <= COUNT_W'(1)) begin
                        n_words_left = '0;
                        n_phase      = PH_FOOT;
                    end else begin
                        n_words_left = w_count - COUNT_W'(1);
                        n_phase      = PH_DATA;
                    end
                end else begin
                    if (r_tally != TALLY_MAX) begin
                        n_tally = r_tally + TALLY_W'(1);
                    end
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    assign o_result.chan_value    = r_store;
    assign o_result.trigger_count = i_word[TRIG_W-1:0];
    assign o_result.source_module = r_module;
    assign o_result.bad_words     = r_tally;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_words_left <= '0;
            r_store      <= '0;
            r_module     <= '0;
            r_tally      <= '0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_words_left <= n_words_left;
            r_store      <= n_store;
            r_module     <= n_module;
            r_tally      <= n_tally;
        end
    end

`ifndef SYNTHESIS
    a_tally_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tally >= $past(r_tally))
        else $error("bad word tally decreased");

    a_last_data_to_foot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_DATA && r_words_left == COUNT_W'(1) |=> r_phase == PH_FOOT)
        else $error("last data word did not lead to footer");

    a_foot_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && r_phase == PH_FOOT |=> r_phase == PH_IDLE)
        else $error("footer did not close the event");
`endif

endmodule

>>> rtl/core/aewd_out_reg.sv
// Result register of the ADC event word deframer.
// Holds one packed result until the receiver takes it; depends on aewd_pkg.
module aewd_out_reg
    import aewd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  t_result               i_result,
    output logic                  o_advance,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [OUT_DATA_W-1:0] o_data
);

    logic                  r_valid;
    logic [OUT_DATA_W-1:0] r_data;

    assign o_advance = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_data    = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= pack_result(i_result);
        end
    end

`ifndef SYNTHESIS
    a_load_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || i_ready))
        else $error("result loaded over an untaken result");
`endif

endmodule
